// File: design/steer_speed_estimator_assert.svh
// Assertion macros shared by the steer speed estimator RTL.
`ifndef STEER_SPEED_ESTIMATOR_ASSERT_SVH
`define STEER_SPEED_ESTIMATOR_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clock, off during reset
`define SSE_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SSE_ASSERT(lbl, ante, cons, msg)
`define SSE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/sse_pkg.sv
// Types and constants of the steer speed estimator.
`default_nettype none

package sse_pkg;

   localparam int POS_W    = 16;
   localparam int TIME_W   = 40;
   localparam int SPEED_W  = 32;
   localparam int WINDOW_W = 5;
   localparam int PROD_W   = 36;
   localparam int NUM_W    = 52;
   localparam int REM_W    = NUM_W - SPEED_W;
   localparam int DIV_STEPS = 32;
   localparam int STEP_W   = 6;
   localparam int WINDOW_RESET = 10;

   localparam logic [PROD_W-1:0]  US_PER_SECOND = PROD_W'(1000000);
   localparam logic [SPEED_W-1:0] SPEED_MAX     = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_FRONT,
      ST_WAIT_FRONT,
      ST_DIV_REAR,
      ST_WAIT_REAR,
      ST_UPDATE,
      ST_DIV_MEAN,
      ST_WAIT_MEAN,
      ST_LOAD
   } state_type;

   typedef enum logic [1:0] {
      SEL_FRONT,
      SEL_REAR,
      SEL_MEAN
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        prep;
      logic        div_start;
      div_sel_type div_sel;
      logic        store_front;
      logic        store_rear;
      logic        update;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: design/sse_req_if.sv
// Sample channel: valid/ready handshake with encoder positions and timestamp.
`default_nettype none

interface sse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sse_pkg::POS_W-1:0]     front_position;
   logic signed [sse_pkg::POS_W-1:0]     rear_position;
   logic        [sse_pkg::TIME_W-1:0]    sample_time_us;

   modport source (
      output valid, front_position, rear_position, sample_time_us,
      input  ready
   );
   modport sink (
      input  valid, front_position, rear_position, sample_time_us,
      output ready
   );
endinterface

`default_nettype wire

// File: design/sse_rsp_if.sv
// Result channel: valid/ready handshake with smoothed speed and saturation flag.
`default_nettype none

interface sse_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sse_pkg::SPEED_W-1:0]      steer_speed;
   logic                             speed_saturated;

   modport source (
      output valid, steer_speed, speed_saturated,
      input  ready
   );
   modport sink (
      input  valid, steer_speed, speed_saturated,
      output ready
   );
endinterface

`default_nettype wire

// File: design/sse_divider.sv
// Shared restoring divider: 52-bit dividend, 40-bit divisor, 32-bit quotient.
`default_nettype none
`include "steer_speed_estimator_assert.svh"

module sse_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sse_pkg::NUM_W-1:0]     dividend,
   input  logic [sse_pkg::TIME_W-1:0]    divisor,
   output logic                          busy,
   output logic [sse_pkg::SPEED_W-1:0]   quotient,
   output logic                          overflow
);

   logic [sse_pkg::TIME_W-1:0]  rem_ff, rem_in;
   logic [sse_pkg::SPEED_W-1:0] quo_ff, quo_in;
   logic [sse_pkg::TIME_W-1:0]  dvs_ff, dvs_in;
   logic                        ovf_ff, ovf_in;
   logic [sse_pkg::STEP_W-1:0]  steps_ff, steps_in;
   logic [sse_pkg::TIME_W:0]    trial;
   logic [sse_pkg::TIME_W:0]    trial_diff;
   logic                        trial_ge;
   logic [sse_pkg::REM_W-1:0]   top_bits;

   assign top_bits   = dividend[sse_pkg::NUM_W-1:sse_pkg::SPEED_W];
   assign trial      = {rem_ff, quo_ff[sse_pkg::SPEED_W-1]};
   assign trial_ge   = trial >= {1'b0, dvs_ff};
   assign trial_diff = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      ovf_in   = ovf_ff;
      steps_in = steps_ff;
      if (start) begin
         // quotient above 32 bits iff the top bits alone reach the divisor
         rem_in   = sse_pkg::TIME_W'(top_bits);
         quo_in   = dividend[sse_pkg::SPEED_W-1:0];
         dvs_in   = divisor;
         ovf_in   = sse_pkg::TIME_W'(top_bits) >= divisor;
         steps_in = sse_pkg::STEP_W'(sse_pkg::DIV_STEPS);
      end else if (steps_ff != '0) begin
         rem_in   = trial_ge ? trial_diff[sse_pkg::TIME_W-1:0] : trial[sse_pkg::TIME_W-1:0];
         quo_in   = {quo_ff[sse_pkg::SPEED_W-2:0], trial_ge};
         steps_in = steps_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      ovf_ff <= ovf_in;
   end

   assign busy     = steps_ff != '0;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

   `SSE_ASSERT(a_no_restart, start, steps_ff == '0, "divider started while busy")

endmodule

`default_nettype wire

// File: design/sse_ctrl.sv
// Controller state machine sequencing capture, three divisions and result load.
`default_nettype none
`include "steer_speed_estimator_assert.svh"

module sse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sse_pkg::status_type  status,
   output sse_pkg::cmd_type     cmd
);

   sse_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (req_valid) state_in = sse_pkg::ST_PREP;
         end
         sse_pkg::ST_PREP:       state_in = sse_pkg::ST_DIV_FRONT;
         sse_pkg::ST_DIV_FRONT:  state_in = sse_pkg::ST_WAIT_FRONT;
         sse_pkg::ST_WAIT_FRONT: begin
            if (!status.div_busy) state_in = sse_pkg::ST_DIV_REAR;
         end
         sse_pkg::ST_DIV_REAR:   state_in = sse_pkg::ST_WAIT_REAR;
         sse_pkg::ST_WAIT_REAR: begin
            if (!status.div_busy) state_in = sse_pkg::ST_UPDATE;
         end
         sse_pkg::ST_UPDATE:     state_in = sse_pkg::ST_DIV_MEAN;
         sse_pkg::ST_DIV_MEAN:   state_in = sse_pkg::ST_WAIT_MEAN;
         sse_pkg::ST_WAIT_MEAN: begin
            if (!status.div_busy) state_in = sse_pkg::ST_LOAD;
         end
         sse_pkg::ST_LOAD: begin
            if (status.out_free) state_in = sse_pkg::ST_IDLE;
         end
         default: state_in = sse_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      cmd.div_sel = sse_pkg::SEL_FRONT;
      case (state_ff)
         sse_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         sse_pkg::ST_PREP: cmd.prep = 1'b1;
         sse_pkg::ST_DIV_FRONT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sse_pkg::SEL_FRONT;
         end
         sse_pkg::ST_WAIT_FRONT: cmd.store_front = !status.div_busy;
         sse_pkg::ST_DIV_REAR: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sse_pkg::SEL_REAR;
         end
         sse_pkg::ST_WAIT_REAR: cmd.store_rear = !status.div_busy;
         sse_pkg::ST_UPDATE: cmd.update = 1'b1;
         sse_pkg::ST_DIV_MEAN: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sse_pkg::SEL_MEAN;
         end
         sse_pkg::ST_WAIT_MEAN: cmd.div_sel = sse_pkg::SEL_MEAN;
         sse_pkg::ST_LOAD: cmd.load_out = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SSE_ASSERT(a_load_when_free, cmd.load_out, status.out_free, "result load into busy output")
   `SSE_ASSERT(a_idle_div_quiet, req_ready, !status.div_busy, "divider busy while idle")

endmodule

`default_nettype wire

// File: design/sse_datapath.sv
// Datapath: sample capture, speed numerators, history store, running sum, output register.
`default_nettype none
`include "steer_speed_estimator_assert.svh"

module sse_datapath #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sse_pkg::cmd_type                    cmd,
   output sse_pkg::status_type                 status,
   input  logic signed [sse_pkg::POS_W-1:0]    req_front,
   input  logic signed [sse_pkg::POS_W-1:0]    req_rear,
   input  logic        [sse_pkg::TIME_W-1:0]   req_time,
   input  logic                                csr_we,
   input  logic        [sse_pkg::WINDOW_W-1:0] csr_wdata,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic        [sse_pkg::SPEED_W-1:0]  rsp_speed,
   output logic                                rsp_sat
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SUM_W = sse_pkg::SPEED_W + CNT_W;
   localparam int WIN_RESET = (WINDOW_MAX < sse_pkg::WINDOW_RESET) ?
                              WINDOW_MAX : sse_pkg::WINDOW_RESET;

   // sample state
   logic signed [sse_pkg::POS_W-1:0]  last_front_ff, last_rear_ff;
   logic        [sse_pkg::TIME_W-1:0] last_time_ff;
   logic        [sse_pkg::TIME_W-1:0] dt_ff;
   logic        [sse_pkg::POS_W-1:0]  dist_f_ff, dist_r_ff;
   logic        [sse_pkg::NUM_W-1:0]  num_f_ff, num_r_ff;
   logic        [sse_pkg::SPEED_W-1:0] sf_ff, sr_ff;
   logic                              sat_ff;

   // history
   logic [sse_pkg::SPEED_W-1:0] hist_mem [WINDOW_MAX];
   logic [sse_pkg::SPEED_W-1:0] old_ff;
   logic [CNT_W-1:0]            win_ff, win_in;
   logic [PTR_W-1:0]            ptr_ff, ptr_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sse_pkg::SPEED_W-1:0] rsp_speed_ff;
   logic                        rsp_sat_ff;

   logic signed [sse_pkg::POS_W:0] diff_f, diff_r;
   logic        [sse_pkg::POS_W:0] mag_f, mag_r;
   logic [sse_pkg::PROD_W-1:0]     prod_f, prod_r;
   logic [sse_pkg::SPEED_W:0]      pair_sum;
   logic [sse_pkg::SPEED_W-1:0]    avg;
   logic                           full;
   logic [sse_pkg::NUM_W-1:0]      div_dividend;
   logic [sse_pkg::TIME_W-1:0]     div_divisor;
   logic                           div_busy;
   logic [sse_pkg::SPEED_W-1:0]    div_quo;
   logic                           div_ovf;

   // |last - new| on 17 bits
   assign diff_f = {last_front_ff[sse_pkg::POS_W-1], last_front_ff}
                 - {req_front[sse_pkg::POS_W-1], req_front};
   assign diff_r = {last_rear_ff[sse_pkg::POS_W-1], last_rear_ff}
                 - {req_rear[sse_pkg::POS_W-1], req_rear};
   assign mag_f  = diff_f[sse_pkg::POS_W] ? (sse_pkg::POS_W+1)'(-diff_f)
                                          : (sse_pkg::POS_W+1)'(diff_f);
   assign mag_r  = diff_r[sse_pkg::POS_W] ? (sse_pkg::POS_W+1)'(-diff_r)
                                          : (sse_pkg::POS_W+1)'(diff_r);

   assign prod_f = sse_pkg::PROD_W'(dist_f_ff) * sse_pkg::US_PER_SECOND;
   assign prod_r = sse_pkg::PROD_W'(dist_r_ff) * sse_pkg::US_PER_SECOND;

   assign pair_sum = {1'b0, sf_ff} + {1'b0, sr_ff};
   assign avg      = pair_sum[sse_pkg::SPEED_W:1];
   assign full     = cnt_ff >= win_ff;

   always_comb begin
      case (cmd.div_sel)
         sse_pkg::SEL_FRONT: begin
            div_dividend = num_f_ff;
            div_divisor  = dt_ff;
         end
         sse_pkg::SEL_REAR: begin
            div_dividend = num_r_ff;
            div_divisor  = dt_ff;
         end
         sse_pkg::SEL_MEAN: begin
            div_dividend = sse_pkg::NUM_W'(sum_ff);
            div_divisor  = sse_pkg::TIME_W'(cnt_ff);
         end
         default: begin
            div_dividend = num_f_ff;
            div_divisor  = dt_ff;
         end
      endcase
   end

   sse_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo),
      .overflow (div_ovf)
   );

   // window register and history bookkeeping; a window write clears the history
   always_comb begin
      win_in = win_ff;
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            win_in = CNT_W'(1);
         end else if (32'(csr_wdata) > 32'(WINDOW_MAX)) begin
            win_in = CNT_W'(WINDOW_MAX);
         end else begin
            win_in = CNT_W'(csr_wdata);
         end
         ptr_in = '0;
         cnt_in = '0;
         sum_in = '0;
      end else if (cmd.update) begin
         sum_in = sum_ff - (full ? SUM_W'(old_ff) : SUM_W'(0)) + SUM_W'(avg);
         cnt_in = full ? cnt_ff : cnt_ff + 1'b1;
         ptr_in = ((CNT_W'(ptr_ff) + 1'b1) == win_ff) ? PTR_W'(0) : ptr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff        <= CNT_W'(WIN_RESET);
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         sum_ff        <= '0;
         last_front_ff <= '0;
         last_rear_ff  <= '0;
         last_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         win_ff       <= win_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.capture) begin
            last_front_ff <= req_front;
            last_rear_ff  <= req_rear;
            last_time_ff  <= req_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dt_ff     <= req_time - last_time_ff;
         dist_f_ff <= mag_f[sse_pkg::POS_W-1:0];
         dist_r_ff <= mag_r[sse_pkg::POS_W-1:0];
      end
      if (cmd.prep) begin
         num_f_ff <= {prod_f, 16'b0};
         num_r_ff <= {prod_r, 16'b0};
      end
      if (cmd.store_front) begin
         sf_ff  <= div_ovf ? sse_pkg::SPEED_MAX : div_quo;
         sat_ff <= div_ovf;
      end
      if (cmd.store_rear) begin
         sr_ff  <= div_ovf ? sse_pkg::SPEED_MAX : div_quo;
         sat_ff <= sat_ff | div_ovf;
      end
      if (cmd.load_out) begin
         rsp_speed_ff <= div_quo;
         rsp_sat_ff   <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         old_ff <= hist_mem[ptr_ff];
      end
      if (cmd.update) begin
         hist_mem[ptr_ff] <= avg;
      end
   end

   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_speed = rsp_speed_ff;
   assign rsp_sat   = rsp_sat_ff;

   `SSE_ASSERT(a_cnt_in_window, 1'b1, cnt_ff <= win_ff, "history count exceeds window")
   `SSE_ASSERT(a_ptr_in_window, 1'b1, CNT_W'(ptr_ff) < win_ff, "history pointer outside window")
   `SSE_ASSERT_NEXT(a_csr_clears, csr_we, cnt_ff == '0 && sum_ff == '0, "window write kept history")

endmodule

`default_nettype wire

// File: design/steer_speed_estimator.sv
// Steer speed estimator top level.
//
// req_chan carries one encoder sample per transfer: front and rear steer
// positions (signed counts) and a 40-bit microsecond timestamp. rsp_chan
// returns exactly one result per sample: the moving-average steer speed in
// Q16.16 counts per second and a flag set when the front or rear speed
// saturated (zero time step or quotient above 32 bits).
// csr_we/csr_wdata write the averaging window (0 acts as 1, values above
// WINDOW_MAX act as WINDOW_MAX) and clear the history; write only when idle.
// For each sample, between its transfer and its result, one shared
// bit-serial divider runs three 32-step divisions in turn (front speed,
// rear speed, window mean), besides capture, multiply, history update
// and output load. req_chan is ready again the cycle after the result is
// loaded, so a new sample is taken only after the last result is loaded.
// The result sits in an output register; a stalled receiver does not stop
// the next sample from being taken, only its own result load waits.
// Reset clears the previous sample to zero, empties the history and sets the
// window to 10 (or WINDOW_MAX if smaller).
`default_nettype none

module steer_speed_estimator #(
   parameter int WINDOW_MAX = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   sse_req_if.sink                             req_chan,
   sse_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic        [sse_pkg::WINDOW_W-1:0] csr_wdata
);

   sse_pkg::cmd_type    cmd;
   sse_pkg::status_type status;

   sse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sse_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_front (req_chan.front_position),
      .req_rear  (req_chan.rear_position),
      .req_time  (req_chan.sample_time_us),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_speed (rsp_chan.steer_speed),
      .rsp_sat   (rsp_chan.speed_saturated)
   );

endmodule

`default_nettype wire
